// ----- rtl/swtg_pkg.sv -----
`timescale 1ns / 1ps

package swtg_pkg;

  // Frequency limits and reset values of the bell registers
  localparam int unsigned FreqW       = 15;
  localparam int unsigned LenW        = 16;
  localparam int unsigned TcW         = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 24;

  localparam logic [FreqW-1:0] FreqMin          = 15'd3;
  localparam logic [FreqW-1:0] FreqMax          = 15'd20000;
  localparam logic [FreqW-1:0] BellPitchReset   = 15'd440;
  localparam logic [LenW-1:0]  BellLengthReset  = 16'd12;

  // 750000 / (4 * f) is taken as (750000 / 4) / f, which gives the same floor
  localparam int unsigned ToneClock   = 750000;
  localparam int unsigned DividendW   = 18;
  localparam logic [DividendW-1:0] ToneDividend = DividendW'(ToneClock / 4);
  localparam int unsigned StepW       = $clog2(DividendW);

  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_PLAY     = 2'd0,
    OP_BELL     = 2'd1,
    OP_DUR_TICK = 2'd2,
    OP_CNT_TICK = 2'd3
  } op_e;

  typedef enum logic {
    CFG_BELL_PITCH  = 1'b0,
    CFG_BELL_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_REJECT   = 2'd1,
    KIND_DUR_TICK = 2'd2,
    KIND_CNT_TICK = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [FreqW-1:0] freq;
    logic [LenW-1:0]  len;
  } cmd_t;

endpackage

// ----- rtl/swtg_front.sv -----
`timescale 1ns / 1ps

module swtg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [swtg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [swtg_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [1:0]                    s_axis_tuser_i,
  input  logic                          full_i,
  output logic                          push_o,
  output swtg_pkg::cmd_t                cmd_o
);

  logic [swtg_pkg::FreqW-1:0] bell_pitch_q, bell_pitch_d;
  logic [swtg_pkg::LenW-1:0]  bell_length_q, bell_length_d;
  swtg_pkg::op_e              op;
  logic [swtg_pkg::FreqW-1:0] in_freq;
  logic [swtg_pkg::LenW-1:0]  in_len;
  logic [swtg_pkg::FreqW-1:0] sel_freq;
  logic [swtg_pkg::LenW-1:0]  sel_len;
  logic                       in_range;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    bell_pitch_d  = bell_pitch_q;
    bell_length_d = bell_length_q;
    if (cfg_valid_i) begin
      unique case (swtg_pkg::cfg_idx_e'(cfg_index_i))
        swtg_pkg::CFG_BELL_PITCH:  bell_pitch_d  = cfg_data_i[swtg_pkg::FreqW-1:0];
        swtg_pkg::CFG_BELL_LENGTH: bell_length_d = cfg_data_i[swtg_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bell_pitch_q  <= swtg_pkg::BellPitchReset;
      bell_length_q <= swtg_pkg::BellLengthReset;
    end else begin
      bell_pitch_q  <= bell_pitch_d;
      bell_length_q <= bell_length_d;
    end
  end

  assign op      = swtg_pkg::op_e'(s_axis_tuser_i);
  assign in_freq = s_axis_tdata_i[swtg_pkg::FreqW-1:0];
  assign in_len  = s_axis_tdata_i[swtg_pkg::FreqW +: swtg_pkg::LenW];

  // Bell requests take pitch and length from the registers
  assign sel_freq = (op == swtg_pkg::OP_BELL) ? bell_pitch_q : in_freq;
  assign sel_len  = (op == swtg_pkg::OP_BELL) ? bell_length_q : in_len;
  assign in_range = (sel_freq >= swtg_pkg::FreqMin) && (sel_freq <= swtg_pkg::FreqMax) &&
                    (sel_len != '0);

  always_comb begin
    cmd_o.freq = sel_freq;
    cmd_o.len  = sel_len;
    unique case (op)
      swtg_pkg::OP_PLAY, swtg_pkg::OP_BELL:
        cmd_o.kind = in_range ? swtg_pkg::KIND_START : swtg_pkg::KIND_REJECT;
      swtg_pkg::OP_DUR_TICK: cmd_o.kind = swtg_pkg::KIND_DUR_TICK;
      swtg_pkg::OP_CNT_TICK: cmd_o.kind = swtg_pkg::KIND_CNT_TICK;
      default:               cmd_o.kind = swtg_pkg::KIND_REJECT;
    endcase
  end

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

endmodule

// ----- rtl/swtg_queue.sv -----
`timescale 1ns / 1ps

module swtg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swtg_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output swtg_pkg::cmd_t cmd_o
);

  swtg_pkg::cmd_t                  slot_q [swtg_pkg::QueueDepth];
  logic [swtg_pkg::QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [swtg_pkg::QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [swtg_pkg::QueueCntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == swtg_pkg::QueueCntW'(swtg_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/swtg_back.sv -----
`timescale 1ns / 1ps

module swtg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  swtg_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [swtg_pkg::OutDataW-1:0] m_axis_tdata_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Tone state
  logic [swtg_pkg::TcW-1:0]  reload_q, reload_d;
  logic [swtg_pkg::TcW-1:0]  down_q, down_d;
  logic                      level_q, level_d;
  logic                      active_q, active_d;
  logic [swtg_pkg::LenW-1:0] ticks_q, ticks_d;

  // Divider
  logic [swtg_pkg::FreqW-1:0]     freq_q, freq_d;
  logic [swtg_pkg::LenW-1:0]      len_q, len_d;
  logic [swtg_pkg::FreqW-1:0]     rem_q, rem_d;
  logic [swtg_pkg::DividendW-1:0] dvd_q, dvd_d;
  logic [swtg_pkg::DividendW-1:0] quo_q, quo_d;
  logic [swtg_pkg::StepW-1:0]     step_q, step_d;
  logic [swtg_pkg::FreqW:0]       trial;
  logic [swtg_pkg::FreqW:0]       diff;
  logic                           fits;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [swtg_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_free;
  logic                          acc;
  logic                          load;

  logic [swtg_pkg::LenW-1:0] ticks_dec;
  logic [swtg_pkg::TcW-1:0]  down_dec;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pop_o    = valid_i && (state_q == ST_IDLE) && out_free;

  assign trial = {rem_q, dvd_q[swtg_pkg::DividendW-1]};
  assign diff  = trial - {1'b0, freq_q};
  assign fits  = trial >= {1'b0, freq_q};

  assign ticks_dec = ticks_q - 1'b1;
  assign down_dec  = down_q - 1'b1;

  always_comb begin
    state_d  = state_q;
    reload_d = reload_q;
    down_d   = down_q;
    level_d  = level_q;
    active_d = active_q;
    ticks_d  = ticks_q;
    freq_d   = freq_q;
    len_d    = len_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    step_d   = step_q;
    acc      = 1'b0;
    load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (cmd_i.kind)
            swtg_pkg::KIND_START: begin
              freq_d  = cmd_i.freq;
              len_d   = cmd_i.len;
              rem_d   = '0;
              dvd_d   = swtg_pkg::ToneDividend;
              quo_d   = '0;
              step_d  = swtg_pkg::StepW'(swtg_pkg::DividendW - 1);
              state_d = ST_DIV;
            end
            swtg_pkg::KIND_DUR_TICK: begin
              load = 1'b1;
              if (active_q) begin
                ticks_d = ticks_dec;
                if (ticks_dec == '0) begin
                  active_d = 1'b0;
                  level_d  = 1'b0;
                end
              end
            end
            swtg_pkg::KIND_CNT_TICK: begin
              load = 1'b1;
              if (active_q) begin
                if (down_dec == '0) begin
                  level_d = !level_q;
                  down_d  = reload_q;
                end else begin
                  down_d = down_dec;
                end
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        // One restoring step per cycle, most significant dividend bit first
        rem_d = fits ? diff[swtg_pkg::FreqW-1:0] : trial[swtg_pkg::FreqW-1:0];
        quo_d = {quo_q[swtg_pkg::DividendW-2:0], fits};
        dvd_d = {dvd_q[swtg_pkg::DividendW-2:0], 1'b0};
        if (step_q == '0) begin
          state_d = ST_WRITE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          reload_d = quo_q[swtg_pkg::TcW-1:0];
          down_d   = quo_q[swtg_pkg::TcW-1:0];
          level_d  = 1'b0;
          active_d = 1'b1;
          ticks_d  = len_q;
          acc      = 1'b1;
          load     = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {(swtg_pkg::OutDataW - swtg_pkg::TcW - 3)'(0),
                     reload_d, acc, active_d, level_d};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reload_q    <= '0;
      down_q      <= '0;
      level_q     <= 1'b0;
      active_q    <= 1'b0;
      ticks_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reload_q    <= reload_d;
      down_q      <= down_d;
      level_q     <= level_d;
      active_q    <= active_d;
      ticks_q     <= ticks_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    len_q      <= len_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_stop_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> !level_q)
    else $error("tone stopped with speaker high");

  a_reload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (reload_q != '0))
    else $error("sounding with zero time constant");

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (quo_q[swtg_pkg::DividendW-1:swtg_pkg::TcW] == '0))
    else $error("time constant overflows 16 bits");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !pop_o)
    else $error("command taken while divider busy");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (step_q == '0) |=> (state_q == ST_WRITE))
    else $error("divider did not finish on last step");

endmodule

// ----- rtl/square_wave_tone_generator_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid_i/tready_o       tdata: freq, duration_ticks; tuser: op
// m_axis    out        m_axis_tvalid_o/tready_i       tdata: speaker, sounding, accepted,
//                                                     time_constant
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// Tick words and rejected requests are done in the back end's idle state as they leave the queue.
// An accepted play or bell word is issued from the idle state, runs 18 restoring divide steps
// of 187500 / freq in the shared divider, then commits once the output register is free.
// Reset (rst_ni low) clears the tone state, the queue and the output valid flag at once.
// A two-word queue lets input words be taken while the divider works or the output stalls.

module square_wave_tone_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [swtg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [14:0] freq, [30:15] duration_ticks, [31] zero
  input  logic [swtg_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] speaker, [1] sounding, [2] accepted, [18:3] time_constant, [23:19] zero
  output logic [swtg_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           queue_valid;
  swtg_pkg::cmd_t front_cmd;
  swtg_pkg::cmd_t queue_cmd;

  swtg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  swtg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  swtg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (queue_valid),
    .cmd_i           (queue_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ----- tb/square_wave_tone_generator_unit_tb.sv -----
`timescale 1ns / 1ps

module square_wave_tone_generator_unit_tb;

  typedef struct {
    logic                     speaker;
    logic                     sounding;
    logic                     accepted;
    logic [swtg_pkg::TcW-1:0] time_constant;
  } tone_report_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_index_i = 1'b0;
  logic [swtg_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [swtg_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  logic [1:0]                    s_axis_tuser_i = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [swtg_pkg::OutDataW-1:0] m_axis_tdata_o;

  // Predicted tone state and bell registers
  logic [swtg_pkg::TcW-1:0]   tone_reload = '0;
  logic [swtg_pkg::TcW-1:0]   tone_count = '0;
  logic                       tone_level = 1'b0;
  logic                       tone_on = 1'b0;
  logic [swtg_pkg::LenW-1:0]  tone_left = '0;
  logic [swtg_pkg::FreqW-1:0] bell_pitch_q = swtg_pkg::BellPitchReset;
  logic [swtg_pkg::LenW-1:0]  bell_len_q = swtg_pkg::BellLengthReset;

  tone_report_t tone_report_q[$];
  int unsigned  fail_count = 0;
  int unsigned  shown_count = 0;
  bit           src_idle_en = 1'b1;
  bit           sink_idle_en = 1'b1;
  int unsigned  hold_left = 0;

  square_wave_tone_generator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [swtg_pkg::FreqW-1:0] rand_freq();
    return swtg_pkg::FreqW'($urandom());
  endfunction

  function automatic logic [swtg_pkg::LenW-1:0] rand_len();
    return swtg_pkg::LenW'($urandom());
  endfunction

  function automatic logic start_tone(input logic [swtg_pkg::FreqW-1:0] f,
                                      input logic [swtg_pkg::LenW-1:0] len);
    int unsigned tc;
    if (f < swtg_pkg::FreqMin || f > swtg_pkg::FreqMax || len == '0) return 1'b0;
    tc = 750000 / (4 * int'(f));
    tone_reload = tc[swtg_pkg::TcW-1:0];
    tone_count  = tone_reload;
    tone_level  = 1'b0;
    tone_on     = 1'b1;
    tone_left   = len;
    return 1'b1;
  endfunction

  function automatic tone_report_t advance_tone(input swtg_pkg::op_e op,
                                                input logic [swtg_pkg::FreqW-1:0] f,
                                                input logic [swtg_pkg::LenW-1:0] len);
    tone_report_t rep;
    logic         acc;
    acc = 1'b0;
    case (op)
      swtg_pkg::OP_PLAY: acc = start_tone(f, len);
      swtg_pkg::OP_BELL: acc = start_tone(bell_pitch_q, bell_len_q);
      swtg_pkg::OP_DUR_TICK: begin
        if (tone_on) begin
          tone_left = tone_left - 1'b1;
          if (tone_left == '0) begin
            tone_on    = 1'b0;
            tone_level = 1'b0;
          end
        end
      end
      default: begin
        if (tone_on) begin
          tone_count = tone_count - 1'b1;
          if (tone_count == '0) begin
            tone_level = ~tone_level;
            tone_count = tone_reload;
          end
        end
      end
    endcase
    rep.speaker       = tone_level;
    rep.sounding      = tone_on;
    rep.accepted      = acc;
    rep.time_constant = tone_reload;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [swtg_pkg::TcW-1:0] want,
                             input logic [swtg_pkg::TcW-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (shown_count < 10) begin
        shown_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
    end
  endtask

  // Check results against the oldest prediction, predict input words, track bell writes
  always @(posedge clk_i) begin
    tone_report_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (tone_report_q.size() == 0) begin
          fail_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("%0t: result word with none outstanding: %h", $realtime, m_axis_tdata_o);
          end
        end else begin
          want = tone_report_q.pop_front();
          check_field("speaker", swtg_pkg::TcW'(want.speaker),
                      swtg_pkg::TcW'(m_axis_tdata_o[0]));
          check_field("sounding", swtg_pkg::TcW'(want.sounding),
                      swtg_pkg::TcW'(m_axis_tdata_o[1]));
          check_field("accepted", swtg_pkg::TcW'(want.accepted),
                      swtg_pkg::TcW'(m_axis_tdata_o[2]));
          check_field("time_constant", want.time_constant, m_axis_tdata_o[18:3]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        tone_report_q.push_back(advance_tone(swtg_pkg::op_e'(s_axis_tuser_i),
                                             s_axis_tdata_i[14:0], s_axis_tdata_i[30:15]));
      if (cfg_valid_i && cfg_ready_o) begin
        if (swtg_pkg::cfg_idx_e'(cfg_index_i) == swtg_pkg::CFG_BELL_PITCH)
          bell_pitch_q = cfg_data_i[swtg_pkg::FreqW-1:0];
        else bell_len_q = cfg_data_i;
      end
    end
  end

  // Receiver: random stalls, or a long hold when one is requested
  initial begin
    int unsigned sink_wait;
    sink_wait = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else if (sink_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (sink_idle_en) sink_wait = pick_gap();
      end
    end
  end

  task automatic send_word(input swtg_pkg::op_e op, input logic [swtg_pkg::FreqW-1:0] f,
                           input logic [swtg_pkg::LenW-1:0] len);
    int unsigned gap;
    gap = src_idle_en ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {1'b0, len, f};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every result word is back, plus a request's latency
  task automatic drain_words();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (tone_report_q.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic write_reg(input swtg_pkg::cfg_idx_e idx,
                           input logic [swtg_pkg::CfgDataW-1:0] data);
    drain_words();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_play_limits();
    send_word(swtg_pkg::OP_DUR_TICK, '1, '1);
    send_word(swtg_pkg::OP_CNT_TICK, '0, '0);
    send_word(swtg_pkg::OP_PLAY, 15'd2, 16'd5);
    send_word(swtg_pkg::OP_PLAY, 15'd3, 16'd0);
    send_word(swtg_pkg::OP_PLAY, 15'd20001, 16'd5);
    send_word(swtg_pkg::OP_PLAY, 15'd32767, 16'd65535);
    send_word(swtg_pkg::OP_PLAY, 15'd0, 16'd1);
    send_word(swtg_pkg::OP_PLAY, 15'd3, 16'd65535);
    // retune to the shortest constant and run it through one full period
    send_word(swtg_pkg::OP_PLAY, 15'd20000, 16'd2);
    repeat (19) send_word(swtg_pkg::OP_CNT_TICK, rand_freq(), rand_len());
    send_word(swtg_pkg::OP_DUR_TICK, rand_freq(), rand_len());
    send_word(swtg_pkg::OP_DUR_TICK, rand_freq(), rand_len());
    send_word(swtg_pkg::OP_BELL, rand_freq(), rand_len());
    repeat (12) send_word(swtg_pkg::OP_DUR_TICK, rand_freq(), rand_len());
  endtask

  task automatic test_bell_registers();
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'd3);
    write_reg(swtg_pkg::CFG_BELL_LENGTH, 16'd1);
    send_word(swtg_pkg::OP_BELL, '0, '0);
    send_word(swtg_pkg::OP_DUR_TICK, '0, '0);
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'd20000);
    write_reg(swtg_pkg::CFG_BELL_LENGTH, 16'd65535);
    send_word(swtg_pkg::OP_BELL, '0, '0);
    repeat (10) send_word(swtg_pkg::OP_CNT_TICK, '0, '0);
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'd2);
    send_word(swtg_pkg::OP_BELL, '0, '0);
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'd20001);
    send_word(swtg_pkg::OP_BELL, '0, '0);
    // top bit lies outside the register and is dropped
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'h8000 | 16'd15000);
    send_word(swtg_pkg::OP_BELL, '0, '0);
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'd32767);
    send_word(swtg_pkg::OP_BELL, '0, '0);
    write_reg(swtg_pkg::CFG_BELL_PITCH, 16'd1000);
    write_reg(swtg_pkg::CFG_BELL_LENGTH, 16'd0);
    send_word(swtg_pkg::OP_BELL, '0, '0);
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_left = 300;
    send_word(swtg_pkg::OP_PLAY, 15'd18000, 16'd4);
    repeat (8) send_word(swtg_pkg::op_e'($urandom_range(2, 3)), rand_freq(), rand_len());
    send_word(swtg_pkg::OP_BELL, '0, '0);
    repeat (6) send_word(swtg_pkg::OP_CNT_TICK, rand_freq(), rand_len());
    src_idle_en = 1'b1;
    drain_words();
  endtask

  function automatic logic [swtg_pkg::FreqW-1:0] pick_freq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return swtg_pkg::FreqW'($urandom_range(12000, 20000));
    if (r < 80) return swtg_pkg::FreqW'($urandom_range(3000, 12000));
    if (r < 85) return swtg_pkg::FreqMin;
    if (r < 90) return swtg_pkg::FreqMax;
    return swtg_pkg::FreqW'($urandom_range(3, 20000));
  endfunction

  task automatic retune_bell();
    int unsigned r;
    logic [swtg_pkg::CfgDataW-1:0] pitch;
    logic [swtg_pkg::CfgDataW-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 70) pitch = swtg_pkg::CfgDataW'(pick_freq());
    else if (r < 85) pitch = swtg_pkg::CfgDataW'($urandom());
    else pitch = swtg_pkg::CfgDataW'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (r < 50) len = swtg_pkg::CfgDataW'($urandom_range(1, 4));
    else if (r < 60) len = 16'd1;
    else if (r < 70) len = 16'hFFFF;
    else if (r < 80) len = 16'd0;
    else len = swtg_pkg::CfgDataW'($urandom());
    write_reg(swtg_pkg::CFG_BELL_PITCH, pitch);
    write_reg(swtg_pkg::CFG_BELL_LENGTH, len);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned r;
    logic [swtg_pkg::LenW-1:0] len;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 150 == 149) retune_bell();
      // whole stretches without idling on either side
      if (i % 100 == 0) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? rand_len() : swtg_pkg::LenW'($urandom_range(1, 6));
      if (r < 8) send_word(swtg_pkg::op_e'($urandom_range(0, 3)), rand_freq(), rand_len());
      else if (r < 20) send_word(swtg_pkg::OP_PLAY, pick_freq(), len);
      else if (r < 23) send_word(swtg_pkg::OP_BELL, rand_freq(), rand_len());
      else if (r < 45) send_word(swtg_pkg::OP_DUR_TICK, rand_freq(), rand_len());
      else send_word(swtg_pkg::OP_CNT_TICK, rand_freq(), rand_len());
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    drain_words();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_play_limits();
    test_bell_registers();
    test_backpressure();
    test_random_traffic(1300);
    fail_count += tone_report_q.size();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swtg_pkg.sv
rtl/swtg_front.sv
rtl/swtg_queue.sv
rtl/swtg_back.sv
rtl/square_wave_tone_generator_unit.sv
tb/square_wave_tone_generator_unit_tb.sv
